// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
// each macro expects clk and rst in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsd assertion failed (same cycle)");

// next-cycle implication, quiet during reset
`define RSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsd assertion failed (next cycle)");

`endif

// ----- src/rsd_pkg.sv -----
// constants for the radial spotlight dimmer
// no dependencies; used by the result and config interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int unsigned CENTER_BITS  = 14;
  localparam int unsigned DIST_BITS    = 8;
  localparam int unsigned DIST_CAP     = 160;
  localparam int unsigned FALLOFF_DEN  = 200;
  localparam int unsigned CFG_IDX_BITS = 2;

  // register indexes on the config channel
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;

endpackage

`default_nettype wire

// ----- src/rsd_pix_if.sv -----
// pixel input channel: valid/ready plus coordinates and luminance
// depends on nothing but its own parameters
`timescale 1ns / 1ps
`default_nettype none

interface rsd_pix_if #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [LUM_BITS-1:0]   lum_in;

  modport source (output valid, output pixel_x, output pixel_y, output lum_in,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input lum_in,
                  output ready);
endinterface

`default_nettype wire

// ----- src/rsd_res_if.sv -----
// result channel: valid/ready plus dimmed luminance and saturated distance
// uses rsd_pkg for the distance width
`timescale 1ns / 1ps
`default_nettype none

interface rsd_res_if #(
  parameter int LUM_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [LUM_BITS-1:0]            lum_out;
  logic [rsd_pkg::DIST_BITS-1:0]  dist_sat;

  modport source (output valid, output lum_out, output dist_sat, input ready);
  modport sink   (input valid, input lum_out, input dist_sat, output ready);
endinterface

`default_nettype wire

// ----- src/rsd_cfg_if.sv -----
// config write channel: valid/ready, register index and write data
// uses rsd_pkg for the index and data widths
`timescale 1ns / 1ps
`default_nettype none

interface rsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rsd_pkg::CFG_IDX_BITS-1:0] index;
  logic [rsd_pkg::CENTER_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/radial_spotlight_dimmer.sv -----
// radial spotlight dimmer: eight-stage pipeline from pixel to dimmed pixel
// depends on rsd_pkg, rsd_pix_if, rsd_res_if, rsd_cfg_if and assert_macros.svh
//
// usage:
//   pix carries one pixel per beat (pixel_x, pixel_y, lum_in); res returns
//   one beat per pixel, in order, with lum_out = floor(lum_in*(200-d)/200)
//   and dist_sat = d = min(ceil(sqrt(dx^2+dy^2)), 160).
//   cfg writes center_x (index 0) or center_y (index 1), 14-bit signed;
//   cfg is always ready, other indexes are dropped. write only while idle.
//   a pixel passes through the eight register stages to res (subtract,
//   magnitude, squares, two half square roots, scale multiply, reciprocal
//   multiply, remainder fix); throughput is one pixel per clock while res
//   takes results.
//   each stage moves when its successor has room, so bubbles are squeezed
//   out and pix.ready stays high while the pipe is not full, even when a
//   result is waiting on res. a stalled result holds in the output register.
//   synchronous reset clears all valid bits and both center registers to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module radial_spotlight_dimmer #(
  parameter int COORD_BITS = 12,
  parameter int LUM_BITS   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rsd_cfg_if.sink    cfg,
  rsd_pix_if.sink    pix,
  rsd_res_if.source  res
);
  import rsd_pkg::*;

  localparam int DW       = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;
  localparam int PW       = LUM_BITS + DIST_BITS;
  localparam int K        = PW + 1;
  localparam int RECIP_W  = K - 7;
  localparam int SAT_SUM  = (DIST_CAP - 1) * (DIST_CAP - 1);
  localparam logic [K:0]         POW_K  = {1'b1, {K{1'b0}}};
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(POW_K / (K+1)'(FALLOFF_DEN));
  localparam logic signed [DW-1:0] CAP_POS = DW'(DIST_CAP);
  localparam logic signed [DW-1:0] CAP_NEG = -CAP_POS;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sq_t;

  // one root bit of the restoring square root, from two radicand bits
  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
    logic [10:0] rem_sh;
    logic [10:0] trial;
    sq_t         r;
    rem_sh = {s.rem, pair};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = 9'(rem_sh - trial);
      r.root = {s.root[6:0], 1'b1};
    end else begin
      r.rem  = rem_sh[8:0];
      r.root = {s.root[6:0], 1'b0};
    end
    return r;
  endfunction

  // config registers
  logic signed [CENTER_BITS-1:0] center_x;
  logic signed [CENTER_BITS-1:0] center_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CENTER_X: center_x <= cfg.data;
        CFG_CENTER_Y: center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;
  logic res_valid;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8 = !res_valid || res.ready;
  assign en7 = !s7_valid || en8;
  assign en6 = !s6_valid || en7;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign pix.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= pix.valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) s3_valid  <= s2_valid;
      if (en4) s4_valid  <= s3_valid;
      if (en5) s5_valid  <= s4_valid;
      if (en6) s6_valid  <= s5_valid;
      if (en7) s7_valid  <= s6_valid;
      if (en8) res_valid <= s7_valid;
    end
  end

  // stage 1: offsets from the center
  logic signed [DW-1:0] px_e, py_e, cx_e, cy_e;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic [LUM_BITS-1:0]  s1_lum;

  assign px_e = signed'({{(DW-COORD_BITS){1'b0}}, pix.pixel_x});
  assign py_e = signed'({{(DW-COORD_BITS){1'b0}}, pix.pixel_y});
  assign cx_e = {{(DW-CENTER_BITS){center_x[CENTER_BITS-1]}}, center_x};
  assign cy_e = {{(DW-CENTER_BITS){center_y[CENTER_BITS-1]}}, center_y};

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx  <= px_e - cx_e;
      s1_dy  <= py_e - cy_e;
      s1_lum <= pix.lum_in;
    end
  end

  // stage 2: magnitudes, far flag when either axis alone reaches the cap
  logic signed [DW-1:0] mag_x, mag_y;
  logic                 far_x, far_y;
  logic [7:0]           s2_mx, s2_my;
  logic                 s2_far;
  logic [LUM_BITS-1:0]  s2_lum;

  assign mag_x = s1_dx[DW-1] ? -s1_dx : s1_dx;
  assign mag_y = s1_dy[DW-1] ? -s1_dy : s1_dy;
  assign far_x = (s1_dx >= CAP_POS) || (s1_dx <= CAP_NEG);
  assign far_y = (s1_dy >= CAP_POS) || (s1_dy <= CAP_NEG);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mx  <= mag_x[7:0];
      s2_my  <= mag_y[7:0];
      s2_far <= far_x || far_y;
      s2_lum <= s1_lum;
    end
  end

  // stage 3: squared distance and saturation
  logic [15:0]         sum2;
  logic [15:0]         s3_sum;
  logic                s3_sat;
  logic [LUM_BITS-1:0] s3_lum;

  assign sum2 = 16'(s2_mx) * 16'(s2_mx) + 16'(s2_my) * 16'(s2_my);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum <= sum2;
      s3_sat <= s2_far || (sum2 > 16'(SAT_SUM));
      s3_lum <= s2_lum;
    end
  end

  // stage 4: upper four root digits
  sq_t                 sq_hi;
  sq_t                 s4_sq;
  logic [7:0]          s4_low;
  logic                s4_sat;
  logic [LUM_BITS-1:0] s4_lum;

  always_comb begin
    sq_hi = '0;
    for (int i = 3; i >= 0; i--) begin
      sq_hi = sqrt_step(sq_hi, s3_sum[8 + 2*i +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sq  <= sq_hi;
      s4_low <= s3_sum[7:0];
      s4_sat <= s3_sat;
      s4_lum <= s3_lum;
    end
  end

  // stage 5: lower four root digits, round up on a nonzero remainder
  sq_t                  sq_lo;
  logic [DIST_BITS-1:0] dist_c;
  logic [DIST_BITS-1:0] s5_dist;
  logic [LUM_BITS-1:0]  s5_lum;

  always_comb begin
    sq_lo = s4_sq;
    for (int i = 3; i >= 0; i--) begin
      sq_lo = sqrt_step(sq_lo, s4_low[2*i +: 2]);
    end
    if (s4_sat) begin
      dist_c = DIST_BITS'(DIST_CAP);
    end else begin
      dist_c = sq_lo.root + DIST_BITS'(sq_lo.rem != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_dist <= dist_c;
      s5_lum  <= s4_lum;
    end
  end

  // stage 6: luminance times (200 - d)
  logic [DIST_BITS-1:0] factor;
  logic [PW-1:0]        s6_prod;
  logic [DIST_BITS-1:0] s6_dist;

  assign factor = DIST_BITS'(FALLOFF_DEN) - s5_dist;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_prod <= PW'(s5_lum) * PW'(factor);
      s6_dist <= s5_dist;
    end
  end

  // stage 7: quotient estimate by reciprocal, low by at most one
  logic [PW+RECIP_W-1:0] qmul;
  logic [LUM_BITS-1:0]   s7_q0;
  logic [PW-1:0]         s7_prod;
  logic [DIST_BITS-1:0]  s7_dist;

  assign qmul = (PW+RECIP_W)'(s6_prod) * (PW+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_q0   <= qmul[K +: LUM_BITS];
      s7_prod <= s6_prod;
      s7_dist <= s6_dist;
    end
  end

  // stage 8: remainder check and output register
  logic [PW-1:0]        fix_rem;
  logic [LUM_BITS-1:0]  lum_out_r;
  logic [DIST_BITS-1:0] dist_r;

  assign fix_rem = s7_prod - PW'(s7_q0) * PW'(FALLOFF_DEN);

  always_ff @(posedge clk) begin
    if (en8) begin
      lum_out_r <= (fix_rem >= PW'(FALLOFF_DEN)) ? s7_q0 + LUM_BITS'(1) : s7_q0;
      dist_r    <= s7_dist;
    end
  end

  assign res.valid    = res_valid;
  assign res.lum_out  = lum_out_r;
  assign res.dist_sat = dist_r;

  `RSD_ASSERT_NXT(a_accept_enters, pix.valid && pix.ready, s1_valid)
  `RSD_ASSERT_IMP(a_sat_bound, s3_valid && !s3_sat, s3_sum <= 16'(SAT_SUM))
  `RSD_ASSERT_IMP(a_dist_cap, s5_valid, s5_dist <= DIST_BITS'(DIST_CAP))
  `RSD_ASSERT_IMP(a_div_fix, s7_valid, fix_rem < PW'(2 * FALLOFF_DEN))

endmodule

`default_nettype wire

// ----- tb/sv/radial_spotlight_dimmer_tb.sv -----
// self-checking bench for radial_spotlight_dimmer: a directed pixel set, then random
// pixels under several centers, checked beat by beat against an in-bench dimming model
// depends on rsd_pkg, rsd_cfg_if, rsd_pix_if, rsd_res_if and the dimmer rtl
`timescale 1ns / 1ps

module radial_spotlight_dimmer_tb;
  import rsd_pkg::*;

  localparam int COORD_W = 12;
  localparam int LUM_W = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int SQUEEZE_CYCLES = 64;

  // indexes with no register behind them, the block drops these writes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG_B = 2'd3;

  typedef struct packed {
    logic [LUM_W-1:0]     lum;
    logic [DIST_BITS-1:0] dist_sat;
  } dimmed_t;

  class spot_board;
    logic signed [CENTER_BITS-1:0] center_x;
    logic signed [CENTER_BITS-1:0] center_y;
    dimmed_t dimmed_q[$];
    int unsigned fails;

    function new();
      center_x = '0;
      center_y = '0;
      fails = 0;
    endfunction

    function void set_center(logic [CFG_IDX_BITS-1:0] idx, logic [CENTER_BITS-1:0] val);
      case (idx)
        CFG_CENTER_X: center_x = val;
        CFG_CENTER_Y: center_y = val;
        default: ;
      endcase
    endfunction

    function dimmed_t dim_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [LUM_W-1:0] lum);
      int px, py, cx, cy;
      longint dx, dy, sq, lum_l;
      int unsigned d;
      dimmed_t r;
      px = x;
      py = y;
      cx = center_x;
      cy = center_y;
      dx = px - cx;
      dy = py - cy;
      sq = dx * dx + dy * dy;
      // ceiling square root, capped once past 159 squared
      if (sq > longint'((DIST_CAP - 1) * (DIST_CAP - 1))) begin
        d = DIST_CAP;
      end else begin
        d = 0;
        while (longint'(d * d) < sq) d++;
      end
      lum_l = lum;
      r.dist_sat = DIST_BITS'(d);
      r.lum = LUM_W'((lum_l * longint'(FALLOFF_DEN - d)) / longint'(FALLOFF_DEN));
      return r;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [LUM_W-1:0] lum);
      dimmed_q.push_back(dim_pixel(x, y, lum));
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fails++;
    endtask

    task check_result(logic [LUM_W-1:0] lum, logic [DIST_BITS-1:0] dist_sat);
      dimmed_t want;
      if (dimmed_q.size() == 0) begin
        report($sformatf("result beat with nothing pending (lum %0d dist %0d)",
                         lum, dist_sat));
      end else begin
        want = dimmed_q.pop_front();
        if (lum !== want.lum)
          report($sformatf("lum_out %0d, expected %0d", lum, want.lum));
        if (dist_sat !== want.dist_sat)
          report($sformatf("dist_sat %0d, expected %0d", dist_sat, want.dist_sat));
      end
    endtask

    function int pending();
      return dimmed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycle_count = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit squeeze_req = 1'b0;
  spot_board board = new();

  rsd_cfg_if cfg_ch();
  rsd_pix_if #(.COORD_BITS(COORD_W), .LUM_BITS(LUM_W)) pix_ch();
  rsd_res_if #(.LUM_BITS(LUM_W)) res_ch();

  radial_spotlight_dimmer #(.COORD_BITS(COORD_W), .LUM_BITS(LUM_W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .pix(pix_ch),
    .res(res_ch)
  );

  always #6 clk = ~clk;

  initial begin
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel_x <= '0;
    pix_ch.pixel_y <= '0;
    pix_ch.lum_in <= '0;
    res_ch.ready <= 1'b0;
  end

  // valid drops after each write to keep back-to-back writes apart
  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CENTER_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_center(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [LUM_W-1:0] lum);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    pix_ch.lum_in <= lum;
    do @(posedge clk); while (!pix_ch.ready);
    board.note_pixel(x, y, lum);
  endtask

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > (1 << COORD_W) - 1) return '1;
    return COORD_W'(v);
  endfunction

  // mostly pixels within 170 of the center on each axis, plus some anywhere on the grid
  task automatic send_random(int n);
    int cx, cy, pick;
    logic [COORD_W-1:0] x, y;
    logic [LUM_W-1:0] lum;
    for (int i = 0; i < n; i++) begin
      cx = board.center_x;
      cy = board.center_y;
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        x = clamp_coord(cx);
        y = clamp_coord(cy);
      end else if (pick < 8) begin
        x = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        y = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      end else begin
        x = clamp_coord(cx + int'($urandom_range(0, 340)) - 170);
        y = clamp_coord(cy + int'($urandom_range(0, 340)) - 170);
      end
      if ($urandom_range(0, 15) == 0)
        lum = $urandom_range(0, 1) ? '1 : '0;
      else
        lum = LUM_W'($urandom_range(0, (1 << LUM_W) - 1));
      push_pixel(x, y, lum);
    end
    pix_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int cx, int cy, int n);
    cfg_write(CFG_CENTER_X, CENTER_BITS'(cx));
    cfg_write(CFG_CENTER_Y, CENTER_BITS'(cy));
    send_random(n);
    wait_drained();
  endtask

  task automatic run_directed();
    push_pixel(0, 0, 16'hFFFF);
    push_pixel(0, 0, 16'h0000);
    push_pixel(0, 0, 16'h0001);
    push_pixel(3, 4, 16'hFFFF);
    push_pixel(1, 1, 16'd40000);
    push_pixel(1, 0, 16'hFFFF);
    push_pixel(0, 1, 16'd199);
    push_pixel(2, 2, 16'd200);
    push_pixel(159, 0, 16'hFFFF);
    push_pixel(0, 159, 16'hFFFF);
    push_pixel(160, 0, 16'hFFFF);
    // just inside and just outside the saturation radius
    push_pixel(112, 112, 16'hFFFF);
    push_pixel(112, 113, 16'hFFFF);
    push_pixel(100, 100, 16'h8000);
    push_pixel(50, 60, 16'hAAAA);
    push_pixel(60, 50, 16'h5555);
    push_pixel(4095, 0, 16'd12345);
    push_pixel(0, 4095, 16'd54321);
    push_pixel(4095, 4095, 16'hFFFF);
    push_pixel(4095, 4095, 16'h0000);
    pix_ch.valid <= 1'b0;
    wait_drained();
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready)
        board.check_result(res_ch.lum_out, res_ch.dist_sat);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left = SQUEEZE_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("radial_spotlight_dimmer regression: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset center at the origin
    run_directed();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    cfg_write(CFG_NO_REG_A, '1);
    cfg_write(CFG_NO_REG_B, '0);
    run_phase(-4096, 8191, 150);
    run_phase(8191, -4096, 150);

    // fill the pipe against a long result stall
    squeeze_req = 1'b1;
    run_phase(0, 0, 200);

    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 9) == 0)
        run_phase(int'($urandom_range(0, 12287)) - 4096,
                  int'($urandom_range(0, 12287)) - 4096, 160);
      else
        run_phase($urandom_range(0, 4095), $urandom_range(0, 4095), 160);
    end

    // closing stretch at full rate
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_phase($urandom_range(0, 4095), $urandom_range(0, 4095), 160);

    if (board.fails == 0 && board.pending() == 0)
      $display("radial_spotlight_dimmer regression: pass");
    else
      $display("radial_spotlight_dimmer regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/rsd_pkg.sv
src/rsd_pix_if.sv
src/rsd_res_if.sv
src/rsd_cfg_if.sv
src/radial_spotlight_dimmer.sv
tb/sv/radial_spotlight_dimmer_tb.sv
